// ===== hdl/fkw_pkg.sv =====
// Shared types, constants and command/status structures for the walk estimator.
`timescale 1ns / 1ps

package fkw_pkg;

    // Fixed-point layout
    localparam int FRAC_BITS = 28;
    localparam int SUM_WIDTH = 48;
    localparam int MUL_W     = 64;
    localparam int RES_W     = 61;
    localparam int LVL_W     = 62;

    localparam logic [30:0]      WEIGHT_ONE = 31'h4000_0000;
    localparam logic [30:0]      PM_MOD     = 31'h7FFF_FFFF;
    localparam logic [14:0]      PM_MULT    = 15'd16807;
    localparam logic [30:0]      SEED_RESET = 31'd123456789;
    localparam logic [RES_W-1:0] PROD_CAP   = {1'b1, {(RES_W-1){1'b0}}};
    localparam logic [LVL_W-1:0] ONE_Q      = LVL_W'(1) << FRAC_BITS;
    localparam logic [SUM_WIDTH-1:0] SUM_MAX = {SUM_WIDTH{1'b1}};

    // Multiplier operations, each with fixed operands and destination
    typedef enum logic [3:0] {
        MO_XX,
        MO_YY,
        MO_SXA,
        MO_SYB,
        MO_PX,
        MO_PY,
        MO_PXX,
        MO_PYY,
        MO_HV,
        MO_DEC,
        MO_WE
    } mul_op_t;

    typedef enum logic [1:0] {
        MV_ZERO,
        MV_NEG,
        MV_POS
    } move_t;

    typedef enum logic [1:0] {
        PH_START,
        PH_PATH,
        PH_STEP
    } phase_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_MUL_GO,
        ST_MUL_WAIT,
        ST_LVL_START,
        ST_PATH_CHECK,
        ST_PATH_INIT,
        ST_HV_COPY,
        ST_DRAW_X1,
        ST_DRAW_X2,
        ST_DRAW_Y1,
        ST_DRAW_Y2,
        ST_MOVE,
        ST_UPDATE,
        ST_STEP_CHECK,
        ST_PATH_END,
        ST_DIV_W_GO,
        ST_DIV_W_WAIT,
        ST_DIV_S_GO,
        ST_DIV_S_WAIT,
        ST_RES_OUT,
        ST_RES_IN
    } ctrl_state_t;

    typedef struct packed {
        logic [31:0] inv_a_squared;
        logic [31:0] inv_b_squared;
        logic [31:0] step_size_h;
        logic [30:0] walk_increment;
        logic [15:0] path_count;
        logic [31:0] step_limit;
    } cfg_t;

    typedef struct packed {
        logic    load_start;
        logic    path_init;
        logic    mul_start;
        mul_op_t mul_op;
        logic    rng_adv;
        logic    dx_wr;
        logic    dy_wr;
        move_t   mv;
        logic    move;
        logic    hv_copy;
        logic    w_update;
        logic    set_hit;
        logic    path_end;
        logic    div_start;
        logic    div_weight;
        logic    res_wr;
        logic    res_inside;
    } dp_cmd_t;

    typedef struct packed {
        logic mul_done;
        logic div_done;
        logic level_gt_one;
        logic level_ge_one;
        logic draw_low;
        logic steps_at_limit;
        logic paths_done;
        logic count_zero;
    } dp_stat_t;

endpackage

// ===== hdl/feynman_kac_walk_estimator.sv =====
// Top level: register port, output stage and controller/datapath pair.
`timescale 1ns / 1ps

// Estimates the Feynman-Kac weight for one start point per input transaction.
// A start point outside the ellipse is answered once the start level check is
// done. A point inside runs path_count random-walk paths; every walk step is
// paced by the single shared multi-cycle multiplier (eleven products per step)
// plus the generator draws, and every path first forms its start potential.
// Two divisions form the means. One item is worked on at a time; the next
// start point is taken while a finished result still waits in the output
// register.
module feynman_kac_walk_estimator (
    input  logic        aclk,
    input  logic        aresetn,
    // start_x [31:0], start_y [63:32]
    input  logic [63:0] s_tdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // weight_mean [30:0], steps_mean [62:31], was_inside [63], limit_hit [64]
    output logic [71:0] m_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import fkw_pkg::*;

    localparam logic [2:0] REG_INV_A = 3'd0;
    localparam logic [2:0] REG_INV_B = 3'd1;
    localparam logic [2:0] REG_STEP_H = 3'd2;
    localparam logic [2:0] REG_INC = 3'd3;
    localparam logic [2:0] REG_PATHS = 3'd4;
    localparam logic [2:0] REG_LIMIT = 3'd5;

    cfg_t     cfg_reg;
    logic     m_valid_reg, m_valid_next;
    dp_cmd_t  cmd;
    dp_stat_t stat;
    logic     out_free;
    logic     cfg_wr;
    logic [30:0] weight_mean;
    logic [31:0] steps_mean;
    logic        was_inside;
    logic        limit_hit;

    // Register writes
    assign cfg_wr = psel & penable & pwrite & pready;
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.inv_a_squared  <= 32'd67108864;
            cfg_reg.inv_b_squared  <= 32'd268435456;
            cfg_reg.step_size_h    <= 32'd429497;
            cfg_reg.walk_increment <= 31'd3796290;
            cfg_reg.path_count     <= 16'd10000;
            cfg_reg.step_limit     <= 32'd16777216;
        end else if (cfg_wr) begin
            unique case (paddr[4:2])
                REG_INV_A:  cfg_reg.inv_a_squared  <= pwdata;
                REG_INV_B:  cfg_reg.inv_b_squared  <= pwdata;
                REG_STEP_H: cfg_reg.step_size_h    <= pwdata;
                REG_INC:    cfg_reg.walk_increment <= pwdata[30:0];
                REG_PATHS:  cfg_reg.path_count     <= pwdata[15:0];
                REG_LIMIT:  cfg_reg.step_limit     <= pwdata;
                default:    ;
            endcase
        end
    end

    // Register reads
    always_comb begin
        unique case (paddr[4:2])
            REG_INV_A:  prdata = cfg_reg.inv_a_squared;
            REG_INV_B:  prdata = cfg_reg.inv_b_squared;
            REG_STEP_H: prdata = cfg_reg.step_size_h;
            REG_INC:    prdata = {1'b0, cfg_reg.walk_increment};
            REG_PATHS:  prdata = {16'd0, cfg_reg.path_count};
            REG_LIMIT:  prdata = cfg_reg.step_limit;
            default:    prdata = 32'd0;
        endcase
    end

    // Output stage: hold the result until the transaction completes
    assign out_free     = !m_valid_reg || m_tready;
    assign m_valid_next = cmd.res_wr | (m_valid_reg & !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, limit_hit, was_inside, steps_mean, weight_mean};

    fkw_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_tvalid),
        .s_ready  (s_tready),
        .out_free (out_free),
        .st       (stat),
        .cmd      (cmd)
    );

    fkw_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .cmd         (cmd),
        .stat        (stat),
        .start_x     (s_tdata[31:0]),
        .start_y     (s_tdata[63:32]),
        .weight_mean (weight_mean),
        .steps_mean  (steps_mean),
        .was_inside  (was_inside),
        .limit_hit   (limit_hit)
    );

endmodule

// ===== hdl/fkw_mul.sv =====
// Multi-cycle 64x64 multiplier with right shift and saturation at 2^60.
`timescale 1ns / 1ps

module fkw_mul (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [fkw_pkg::MUL_W-1:0] a,
    input  logic [fkw_pkg::MUL_W-1:0] b,
    input  logic                      shift_wide,
    output logic                      done,
    output logic [fkw_pkg::RES_W-1:0] result
);
    import fkw_pkg::*;

    logic                   busy_reg;
    logic [2:0]             cnt_reg;
    logic                   done_reg;
    logic [MUL_W-1:0]       a_reg, b_reg;
    logic                   wide_reg;
    logic [63:0]            pp_reg;
    logic [1:0]             off_reg;
    logic [127:0]           acc_reg;
    logic [RES_W-1:0]       res_reg;

    logic [31:0]  a_half, b_half;
    logic [63:0]  pp_next;
    logic [127:0] acc_add;
    logic [127:0] shifted;
    logic [RES_W-1:0] capped;

    // Pick the 32-bit halves for this partial product
    assign a_half  = cnt_reg[0] ? a_reg[63:32] : a_reg[31:0];
    assign b_half  = cnt_reg[1] ? b_reg[63:32] : b_reg[31:0];
    assign pp_next = 64'(a_half) * 64'(b_half);
    assign acc_add = acc_reg + ({64'b0, pp_reg} << {off_reg, 5'b0});

    // Scale and saturate the full product
    assign shifted = wide_reg ? (acc_reg >> 32) : (acc_reg >> FRAC_BITS);
    always_comb begin
        if ((|shifted[127:RES_W]) || (shifted[RES_W-1] && (|shifted[RES_W-2:0]))) begin
            capped = PROD_CAP;
        end else begin
            capped = shifted[RES_W-1:0];
        end
    end

    // Sequence control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= 3'd0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 3'd0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 3'd1;
                if (cnt_reg == 3'd5) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Partial products and accumulation
    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg    <= a;
            b_reg    <= b;
            wide_reg <= shift_wide;
            acc_reg  <= '0;
        end else if (busy_reg) begin
            if (cnt_reg <= 3'd3) begin
                pp_reg  <= pp_next;
                off_reg <= {1'b0, cnt_reg[0]} + {1'b0, cnt_reg[1]};
            end
            if (cnt_reg >= 3'd1 && cnt_reg <= 3'd4) begin
                acc_reg <= acc_add;
            end
            if (cnt_reg == 3'd5) begin
                res_reg <= capped;
            end
        end
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

// ===== hdl/fkw_div.sv =====
// Restoring divider, one quotient bit per cycle, for the final means.
`timescale 1ns / 1ps

module fkw_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [fkw_pkg::SUM_WIDTH-1:0] dividend,
    input  logic [15:0]                   divisor,
    output logic                          done,
    output logic [fkw_pkg::SUM_WIDTH-1:0] quotient
);
    import fkw_pkg::*;

    localparam int CNT_W = $clog2(SUM_WIDTH + 1);

    logic                 busy_reg;
    logic                 done_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [SUM_WIDTH-1:0] q_reg;
    logic [15:0]          rem_reg;
    logic [15:0]          div_reg;

    logic [16:0] trial;
    logic [16:0] diff;
    logic        ge;

    // Shift in the next dividend bit and try a subtraction
    assign trial = {rem_reg, q_reg[SUM_WIDTH-1]};
    assign diff  = trial - {1'b0, div_reg};
    assign ge    = trial >= {1'b0, div_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(SUM_WIDTH - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            q_reg   <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= ge ? diff[15:0] : trial[15:0];
            q_reg   <= {q_reg[SUM_WIDTH-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

// ===== hdl/fkw_datapath.sv =====
// Walker datapath: position, weight, generator, sums and arithmetic units.
`timescale 1ns / 1ps

module fkw_datapath (
    input  logic              aclk,
    input  logic              aresetn,
    input  fkw_pkg::cfg_t     cfg,
    input  fkw_pkg::dp_cmd_t  cmd,
    output fkw_pkg::dp_stat_t stat,
    input  logic [31:0]       start_x,
    input  logic [31:0]       start_y,
    output logic [30:0]       weight_mean,
    output logic [31:0]       steps_mean,
    output logic              was_inside,
    output logic              limit_hit
);
    import fkw_pkg::*;

    // Walk state
    logic [31:0]          sx_reg, sy_reg;
    logic [31:0]          x_reg, y_reg;
    logic [31:0]          dx_reg, dy_reg;
    logic [30:0]          w_reg;
    logic [RES_W-1:0]     hv_old_reg, hv_new_reg;
    logic [RES_W-1:0]     tmp_a_reg, tmp_b_reg;
    logic [30:0]          seed_reg;
    logic [SUM_WIDTH-1:0] weight_sum_reg, step_total_reg;
    logic [15:0]          path_idx_reg;
    logic [31:0]          path_steps_reg;
    logic                 hit_reg;
    mul_op_t              op_reg;
    logic                 div_w_reg;
    logic [SUM_WIDTH-1:0] q_w_reg, q_s_reg;

    // Result holding registers
    logic [30:0] res_w_reg;
    logic [31:0] res_s_reg;
    logic        res_in_reg;
    logic        res_hit_reg;

    logic [31:0]      mag_x, mag_y;
    logic [LVL_W-1:0] tmp_sum;
    logic [63:0]      pot;
    logic [RES_W-1:0] we;
    logic [LVL_W-1:0] t_sum;
    logic [RES_W-1:0] half;
    logic [30:0]      w_new;
    logic [45:0]      rng_prod;
    logic [31:0]      rng_fold;
    logic [30:0]      rng_next;
    logic [31:0]      step_mv;
    logic [32:0]      x_sum, y_sum;
    logic [31:0]      x_sat, y_sat;
    logic [SUM_WIDTH:0] wsum_add;
    logic [MUL_W-1:0] mul_a, mul_b;
    logic             mul_wide;
    logic             mul_done;
    logic [RES_W-1:0] mul_res;
    logic             div_done;
    logic [SUM_WIDTH-1:0] div_q;

    // Magnitudes and combined values
    assign mag_x   = x_reg[31] ? (~x_reg + 32'd1) : x_reg;
    assign mag_y   = y_reg[31] ? (~y_reg + 32'd1) : y_reg;
    assign tmp_sum = LVL_W'(tmp_a_reg) + LVL_W'(tmp_b_reg);
    assign pot     = {1'b0, tmp_sum, 1'b0} + 64'(cfg.inv_a_squared)
                     + 64'(cfg.inv_b_squared);
    assign we      = (RES_W'(w_reg) > tmp_a_reg) ? (RES_W'(w_reg) - tmp_a_reg) : '0;
    assign t_sum   = tmp_sum;
    assign half    = t_sum[LVL_W-1:1];
    assign w_new   = (RES_W'(w_reg) > half) ? (w_reg - half[30:0]) : 31'd0;

    // Park-Miller step: fold the product over 2^31-1
    assign rng_prod = 46'(seed_reg) * 46'(PM_MULT);
    assign rng_fold = 32'(rng_prod[30:0]) + 32'(rng_prod[45:31]);
    assign rng_next = (rng_fold >= 32'(PM_MOD)) ? 31'(rng_fold - 32'(PM_MOD))
                                                : rng_fold[30:0];

    // Signed step for this axis
    always_comb begin
        case (cmd.mv)
            MV_NEG:  step_mv = ~{1'b0, cfg.walk_increment} + 32'd1;
            MV_POS:  step_mv = {1'b0, cfg.walk_increment};
            default: step_mv = 32'd0;
        endcase
    end

    // Saturating moves
    assign x_sum = {x_reg[31], x_reg} + {dx_reg[31], dx_reg};
    assign y_sum = {y_reg[31], y_reg} + {dy_reg[31], dy_reg};
    assign x_sat = (x_sum[32] != x_sum[31]) ? (x_sum[32] ? 32'h8000_0000 : 32'h7FFF_FFFF)
                                            : x_sum[31:0];
    assign y_sat = (y_sum[32] != y_sum[31]) ? (y_sum[32] ? 32'h8000_0000 : 32'h7FFF_FFFF)
                                            : y_sum[31:0];

    assign wsum_add = {1'b0, weight_sum_reg} + (SUM_WIDTH+1)'(w_reg);

    // Multiplier operand selection
    always_comb begin
        mul_wide = 1'b0;
        unique case (cmd.mul_op)
            MO_XX:   begin mul_a = 64'(mag_x);          mul_b = 64'(mag_x); end
            MO_YY:   begin mul_a = 64'(mag_y);          mul_b = 64'(mag_y); end
            MO_SXA:  begin mul_a = 64'(tmp_a_reg);      mul_b = 64'(cfg.inv_a_squared); end
            MO_SYB:  begin mul_a = 64'(tmp_b_reg);      mul_b = 64'(cfg.inv_b_squared); end
            MO_PX:   begin mul_a = 64'(mag_x);          mul_b = 64'(cfg.inv_a_squared); end
            MO_PY:   begin mul_a = 64'(mag_y);          mul_b = 64'(cfg.inv_b_squared); end
            MO_PXX:  begin mul_a = 64'(tmp_a_reg);      mul_b = 64'(tmp_a_reg); end
            MO_PYY:  begin mul_a = 64'(tmp_b_reg);      mul_b = 64'(tmp_b_reg); end
            MO_HV:   begin
                mul_a    = 64'(cfg.step_size_h);
                mul_b    = pot;
                mul_wide = 1'b1;
            end
            MO_DEC:  begin mul_a = 64'(hv_old_reg);     mul_b = 64'(w_reg); end
            MO_WE:   begin mul_a = 64'(hv_new_reg);     mul_b = 64'(we); end
            default: begin mul_a = '0;                  mul_b = '0; end
        endcase
    end

    fkw_mul u_mul (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (cmd.mul_start),
        .a          (mul_a),
        .b          (mul_b),
        .shift_wide (mul_wide),
        .done       (mul_done),
        .result     (mul_res)
    );

    fkw_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (cmd.div_weight ? weight_sum_reg : step_total_reg),
        .divisor  (cfg.path_count),
        .done     (div_done),
        .quotient (div_q)
    );

    // Counters, generator and flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg       <= SEED_RESET;
            weight_sum_reg <= '0;
            step_total_reg <= '0;
            path_idx_reg   <= '0;
            path_steps_reg <= '0;
            hit_reg        <= 1'b0;
        end else begin
            if (cmd.rng_adv) begin
                seed_reg <= rng_next;
            end
            if (cmd.load_start) begin
                weight_sum_reg <= '0;
                step_total_reg <= '0;
                path_idx_reg   <= '0;
                hit_reg        <= 1'b0;
            end
            if (cmd.path_init) begin
                path_steps_reg <= '0;
            end
            if (cmd.move) begin
                path_steps_reg <= path_steps_reg + 32'd1;
                if (step_total_reg != SUM_MAX) begin
                    step_total_reg <= step_total_reg + SUM_WIDTH'(1);
                end
            end
            if (cmd.set_hit) begin
                hit_reg <= 1'b1;
            end
            if (cmd.path_end) begin
                weight_sum_reg <= wsum_add[SUM_WIDTH] ? SUM_MAX : wsum_add[SUM_WIDTH-1:0];
                path_idx_reg   <= path_idx_reg + 16'd1;
            end
        end
    end

    // Position, weight and product registers
    always_ff @(posedge aclk) begin
        if (cmd.load_start) begin
            sx_reg <= start_x;
            sy_reg <= start_y;
            x_reg  <= start_x;
            y_reg  <= start_y;
        end
        if (cmd.path_init) begin
            x_reg <= sx_reg;
            y_reg <= sy_reg;
            w_reg <= WEIGHT_ONE;
        end
        if (cmd.dx_wr) begin
            dx_reg <= step_mv;
        end
        if (cmd.dy_wr) begin
            dy_reg <= step_mv;
        end
        if (cmd.move) begin
            x_reg <= x_sat;
            y_reg <= y_sat;
        end
        if (cmd.w_update) begin
            w_reg <= w_new;
        end
        if (cmd.hv_copy) begin
            hv_old_reg <= hv_new_reg;
        end
        if (cmd.mul_start) begin
            op_reg <= cmd.mul_op;
        end
        if (mul_done) begin
            unique case (op_reg)
                MO_XX, MO_SXA, MO_PX, MO_PXX, MO_DEC: tmp_a_reg <= mul_res;
                MO_YY, MO_SYB, MO_PY, MO_PYY, MO_WE:  tmp_b_reg <= mul_res;
                MO_HV:                                hv_new_reg <= mul_res;
                default:                              tmp_a_reg <= mul_res;
            endcase
        end
        if (cmd.div_start) begin
            div_w_reg <= cmd.div_weight;
        end
        if (div_done) begin
            if (div_w_reg) begin
                q_w_reg <= div_q;
            end else begin
                q_s_reg <= div_q;
            end
        end
        // Capture the answer for the output stage
        if (cmd.res_wr) begin
            if (!cmd.res_inside) begin
                res_w_reg   <= WEIGHT_ONE;
                res_s_reg   <= 32'd0;
                res_in_reg  <= 1'b0;
                res_hit_reg <= 1'b0;
            end else if (cfg.path_count == 16'd0) begin
                res_w_reg   <= 31'd0;
                res_s_reg   <= 32'd0;
                res_in_reg  <= 1'b1;
                res_hit_reg <= 1'b0;
            end else begin
                res_w_reg   <= q_w_reg[30:0];
                res_s_reg   <= (|q_s_reg[SUM_WIDTH-1:32]) ? 32'hFFFF_FFFF : q_s_reg[31:0];
                res_in_reg  <= 1'b1;
                res_hit_reg <= hit_reg;
            end
        end
    end

    // Status towards the controller
    assign stat.mul_done       = mul_done;
    assign stat.div_done       = div_done;
    assign stat.level_gt_one   = tmp_sum > ONE_Q;
    assign stat.level_ge_one   = tmp_sum >= ONE_Q;
    assign stat.draw_low       = ~rng_next[30];
    assign stat.steps_at_limit = path_steps_reg >= cfg.step_limit;
    assign stat.paths_done     = path_idx_reg >= cfg.path_count;
    assign stat.count_zero     = cfg.path_count == 16'd0;

    assign weight_mean = res_w_reg;
    assign steps_mean  = res_s_reg;
    assign was_inside  = res_in_reg;
    assign limit_hit   = res_hit_reg;

`ifndef ASSERT_OFF
    // The path weight never rises above one
    a_weight_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(cmd.w_update) |-> (w_reg <= WEIGHT_ONE))
        else $error("path weight above one");

    // The generator never falls into the all-zero state
    a_seed_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        seed_reg != 31'd0)
        else $error("generator seed is zero");

    // A captured mean weight never exceeds one
    a_mean_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(cmd.res_wr) |-> (res_w_reg <= WEIGHT_ONE))
        else $error("mean weight above one");
`endif

endmodule

// ===== hdl/fkw_ctrl.sv =====
// Sequencer for start check, path loop, walk steps and final division.
`timescale 1ns / 1ps

module fkw_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              out_free,
    input  fkw_pkg::dp_stat_t st,
    output fkw_pkg::dp_cmd_t  cmd
);
    import fkw_pkg::*;

    ctrl_state_t state_reg, state_next;
    mul_op_t     op_reg, op_next;
    phase_t      ph_reg, ph_next;

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            op_reg    <= MO_XX;
            ph_reg    <= PH_START;
        end else begin
            state_reg <= state_next;
            op_reg    <= op_next;
            ph_reg    <= ph_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        op_next    = op_reg;
        ph_next    = ph_reg;
        cmd        = '0;
        cmd.mul_op = op_reg;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_start = 1'b1;
                    op_next        = MO_XX;
                    ph_next        = PH_START;
                    state_next     = ST_MUL_GO;
                end
            end
            ST_MUL_GO: begin
                cmd.mul_start = 1'b1;
                state_next    = ST_MUL_WAIT;
            end
            ST_MUL_WAIT: begin
                if (st.mul_done) begin
                    state_next = ST_MUL_GO;
                    unique case (op_reg)
                        MO_XX:  op_next = MO_YY;
                        MO_YY:  op_next = MO_SXA;
                        MO_SXA: op_next = MO_SYB;
                        MO_SYB: state_next = (ph_reg == PH_START) ? ST_LVL_START
                                                                  : ST_STEP_CHECK;
                        MO_PX:  op_next = MO_PY;
                        MO_PY:  op_next = MO_PXX;
                        MO_PXX: op_next = MO_PYY;
                        MO_PYY: op_next = MO_HV;
                        MO_HV: begin
                            if (ph_reg == PH_PATH) begin
                                state_next = ST_HV_COPY;
                            end else begin
                                op_next = MO_DEC;
                            end
                        end
                        MO_DEC: op_next = MO_WE;
                        MO_WE:  state_next = ST_UPDATE;
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_LVL_START: begin
                state_next = st.level_gt_one ? ST_RES_OUT : ST_PATH_CHECK;
            end
            ST_PATH_CHECK: begin
                if (!st.paths_done) begin
                    state_next = ST_PATH_INIT;
                end else if (st.count_zero) begin
                    state_next = ST_RES_IN;
                end else begin
                    state_next = ST_DIV_W_GO;
                end
            end
            ST_PATH_INIT: begin
                cmd.path_init = 1'b1;
                op_next       = MO_PX;
                ph_next       = PH_PATH;
                state_next    = ST_MUL_GO;
            end
            ST_HV_COPY: begin
                cmd.hv_copy = 1'b1;
                ph_next     = PH_STEP;
                state_next  = ST_DRAW_X1;
            end
            ST_DRAW_X1: begin
                cmd.rng_adv = 1'b1;
                if (st.draw_low) begin
                    state_next = ST_DRAW_X2;
                end else begin
                    cmd.dx_wr  = 1'b1;
                    cmd.mv     = MV_ZERO;
                    state_next = ST_DRAW_Y1;
                end
            end
            ST_DRAW_X2: begin
                cmd.rng_adv = 1'b1;
                cmd.dx_wr   = 1'b1;
                cmd.mv      = st.draw_low ? MV_NEG : MV_POS;
                state_next  = ST_DRAW_Y1;
            end
            ST_DRAW_Y1: begin
                cmd.rng_adv = 1'b1;
                if (st.draw_low) begin
                    state_next = ST_DRAW_Y2;
                end else begin
                    cmd.dy_wr  = 1'b1;
                    cmd.mv     = MV_ZERO;
                    state_next = ST_MOVE;
                end
            end
            ST_DRAW_Y2: begin
                cmd.rng_adv = 1'b1;
                cmd.dy_wr   = 1'b1;
                cmd.mv      = st.draw_low ? MV_NEG : MV_POS;
                state_next  = ST_MOVE;
            end
            ST_MOVE: begin
                cmd.move   = 1'b1;
                op_next    = MO_PX;
                state_next = ST_MUL_GO;
            end
            ST_UPDATE: begin
                cmd.w_update = 1'b1;
                cmd.hv_copy  = 1'b1;
                op_next      = MO_XX;
                state_next   = ST_MUL_GO;
            end
            ST_STEP_CHECK: begin
                if (st.level_ge_one) begin
                    state_next = ST_PATH_END;
                end else if (st.steps_at_limit) begin
                    cmd.set_hit = 1'b1;
                    state_next  = ST_PATH_END;
                end else begin
                    state_next = ST_DRAW_X1;
                end
            end
            ST_PATH_END: begin
                cmd.path_end = 1'b1;
                state_next   = ST_PATH_CHECK;
            end
            ST_DIV_W_GO: begin
                cmd.div_start  = 1'b1;
                cmd.div_weight = 1'b1;
                state_next     = ST_DIV_W_WAIT;
            end
            ST_DIV_W_WAIT: begin
                if (st.div_done) begin
                    state_next = ST_DIV_S_GO;
                end
            end
            ST_DIV_S_GO: begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV_S_WAIT;
            end
            ST_DIV_S_WAIT: begin
                if (st.div_done) begin
                    state_next = ST_RES_IN;
                end
            end
            ST_RES_OUT: begin
                if (out_free) begin
                    cmd.res_wr = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_RES_IN: begin
                if (out_free) begin
                    cmd.res_wr     = 1'b1;
                    cmd.res_inside = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

`ifndef ASSERT_OFF
    a_mul_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.mul_start |=> !st.mul_done)
        else $error("multiplier finished in one cycle");

    a_mul_done_waiting: assert property (@(posedge aclk) disable iff (!aresetn)
        st.mul_done |-> (state_reg == ST_MUL_WAIT))
        else $error("product arrived outside the wait state");

    a_div_done_waiting: assert property (@(posedge aclk) disable iff (!aresetn)
        st.div_done |-> (state_reg == ST_DIV_W_WAIT || state_reg == ST_DIV_S_WAIT))
        else $error("quotient arrived outside a wait state");

    a_result_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.res_wr |-> out_free)
        else $error("result written over a pending transaction");
`endif

endmodule

// ===== sim/feynman_kac_walk_estimator_test.sv =====
// Self-checking testbench for the Feynman-Kac random-walk estimator.
`timescale 1ns / 1ps

module feynman_kac_walk_estimator_test;
    import fkw_pkg::*;

    localparam logic [4:0] REG_INV_A    = 5'd0;
    localparam logic [4:0] REG_INV_B    = 5'd4;
    localparam logic [4:0] REG_STEP_H   = 5'd8;
    localparam logic [4:0] REG_WALK_INC = 5'd12;
    localparam logic [4:0] REG_PATHS    = 5'd16;
    localparam logic [4:0] REG_STEP_LIM = 5'd20;

    localparam logic [63:0] MUL_CAP     = 64'h1000_0000_0000_0000;
    localparam longint      CYCLE_LIMIT = 3000000;
    localparam int          LONG_HOLD   = 20000;

    typedef struct packed {
        logic        limit_hit;
        logic        was_inside;
        logic [31:0] steps_mean;
        logic [30:0] weight_mean;
    } walk_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic [63:0] s_tdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] m_tdata;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // Predictor copy of configuration and generator state
    cfg_t        walk_cfg;
    logic [30:0] walk_seed;

    logic [63:0]  start_points[$];
    walk_result_t expected_results[$];
    int           send_idle_pct = 0;
    int           recv_idle_pct = 0;
    logic         send_hold = 1'b0;
    logic         recv_hold_go = 1'b0;
    int           recv_hold_used = 0;
    int           error_count = 0;
    longint       cycle_count = 0;

    feynman_kac_walk_estimator dut (.*);

    always #5 aclk = ~aclk;

    // floor(a*b / 2^s), capped at 2^60
    function automatic logic [63:0] scaled_product(logic [63:0] a, logic [63:0] b, int s);
        logic [127:0] p;
        p = (128'(a) * 128'(b)) >> s;
        return (p > 128'(MUL_CAP)) ? MUL_CAP : p[63:0];
    endfunction

    function automatic logic [63:0] magnitude(longint v);
        return (v < 0) ? 64'(-v) : 64'(v);
    endfunction

    function automatic logic [63:0] level_at(longint x, longint y);
        logic [63:0] sx, sy;
        sx = scaled_product(magnitude(x), magnitude(x), FRAC_BITS);
        sy = scaled_product(magnitude(y), magnitude(y), FRAC_BITS);
        return scaled_product(sx, 64'(walk_cfg.inv_a_squared), FRAC_BITS)
             + scaled_product(sy, 64'(walk_cfg.inv_b_squared), FRAC_BITS);
    endfunction

    function automatic logic [63:0] damping_at(longint x, longint y);
        logic [63:0] px, py, pot;
        px  = scaled_product(magnitude(x), 64'(walk_cfg.inv_a_squared), FRAC_BITS);
        py  = scaled_product(magnitude(y), 64'(walk_cfg.inv_b_squared), FRAC_BITS);
        pot = 2 * (scaled_product(px, px, FRAC_BITS) + scaled_product(py, py, FRAC_BITS))
            + 64'(walk_cfg.inv_a_squared) + 64'(walk_cfg.inv_b_squared);
        return scaled_product(64'(walk_cfg.step_size_h), pot, 32);
    endfunction

    function automatic logic [30:0] next_draw();
        walk_seed = 31'((64'(walk_seed) * 64'(PM_MULT)) % 64'(PM_MOD));
        return walk_seed;
    endfunction

    function automatic longint axis_move();
        if (next_draw() < 31'h4000_0000) begin
            if (next_draw() < 31'h4000_0000)
                return -longint'(walk_cfg.walk_increment);
            return longint'(walk_cfg.walk_increment);
        end
        return 0;
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // Walk every path for one start point and form the means
    function automatic walk_result_t estimate_walk(logic [63:0] point);
        walk_result_t r;
        longint       sx, sy, wx, wy, dx, dy;
        logic [63:0]  wsum, stotal, w, hvs, hvh, dec, we, t, half, smean;
        logic [31:0]  psteps;
        logic         hit;
        sx = longint'($signed(point[31:0]));
        sy = longint'($signed(point[63:32]));
        r = '0;
        hit = 1'b0;
        if (level_at(sx, sy) > 64'(1) << FRAC_BITS) begin
            r.weight_mean = WEIGHT_ONE;
            return r;
        end
        r.was_inside = 1'b1;
        wsum = 0;
        stotal = 0;
        for (int p = 0; p < int'(walk_cfg.path_count); p++) begin
            wx = sx;
            wy = sy;
            w = 64'(WEIGHT_ONE);
            psteps = 0;
            forever begin
                dx = axis_move();
                dy = axis_move();
                hvs = damping_at(wx, wy);
                wx = clamp32(wx + dx);
                wy = clamp32(wy + dy);
                psteps++;
                if (stotal < 64'(SUM_MAX)) stotal++;
                hvh = damping_at(wx, wy);
                dec = scaled_product(hvs, w, FRAC_BITS);
                we = (w > dec) ? w - dec : 0;
                t = scaled_product(hvh, we, FRAC_BITS) + dec;
                half = t >> 1;
                w = (w > half) ? 64'(32'(w - half)) : 0;
                if (level_at(wx, wy) >= 64'(1) << FRAC_BITS) break;
                if (psteps >= walk_cfg.step_limit) begin
                    hit = 1'b1;
                    break;
                end
            end
            wsum = (64'(SUM_MAX) - wsum < w) ? 64'(SUM_MAX) : wsum + w;
        end
        if (walk_cfg.path_count == 0) return r;
        smean = stotal / 64'(walk_cfg.path_count);
        r.steps_mean = (smean > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : smean[31:0];
        r.weight_mean = 31'(wsum / 64'(walk_cfg.path_count));
        r.limit_hit = hit;
        return r;
    endfunction

    // Driver: advance to the next start point once the current one is taken
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid)
                expected_results.push_back(estimate_walk(s_tdata));
            if (start_points.size() > 0 && !send_hold
                    && $urandom_range(99) >= send_idle_pct) begin
                s_tdata  <= start_points.pop_front();
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result ready: one long hold-off on request, else random stalls
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (recv_hold_go && recv_hold_used < LONG_HOLD) begin
            m_tready <= 1'b0;
            recv_hold_used <= recv_hold_used + 1;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Monitor: compare each result transaction with the oldest expectation
    always @(posedge aclk) begin
        walk_result_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[64:0];
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                error_count++;
            end else begin
                want = expected_results.pop_front();
                if (got.weight_mean !== want.weight_mean) begin
                    $display("%0t: weight_mean expected %h actual %h",
                             $time, want.weight_mean, got.weight_mean);
                    error_count++;
                end
                if (got.steps_mean !== want.steps_mean) begin
                    $display("%0t: steps_mean expected %h actual %h",
                             $time, want.steps_mean, got.steps_mean);
                    error_count++;
                end
                if (got.was_inside !== want.was_inside) begin
                    $display("%0t: was_inside expected %b actual %b",
                             $time, want.was_inside, got.was_inside);
                    error_count++;
                end
                if (got.limit_hit !== want.limit_hit) begin
                    $display("%0t: limit_hit expected %b actual %b",
                             $time, want.limit_hit, got.limit_hit);
                    error_count++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic write_reg(logic [4:0] addr, logic [31:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (addr)
            REG_INV_A:    walk_cfg.inv_a_squared  = value;
            REG_INV_B:    walk_cfg.inv_b_squared  = value;
            REG_STEP_H:   walk_cfg.step_size_h    = value;
            REG_WALK_INC: walk_cfg.walk_increment = value[30:0];
            REG_PATHS:    walk_cfg.path_count     = value[15:0];
            REG_STEP_LIM: walk_cfg.step_limit     = value;
            default: ;
        endcase
    endtask

    task automatic write_all(logic [31:0] ia, logic [31:0] ib, logic [31:0] h,
                             logic [31:0] inc, logic [31:0] paths, logic [31:0] lim);
        write_reg(REG_INV_A, ia);
        write_reg(REG_INV_B, ib);
        write_reg(REG_STEP_H, h);
        write_reg(REG_WALK_INC, inc);
        write_reg(REG_PATHS, paths);
        write_reg(REG_STEP_LIM, lim);
    endtask

    // Hold until every queued start point is taken and answered
    task automatic wait_drained();
        @(negedge aclk);
        while (start_points.size() > 0 || s_tvalid || expected_results.size() > 0)
            @(negedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic add_point(logic [31:0] x, logic [31:0] y);
        start_points.push_back({y, x});
    endtask

    // Random point: full-range bits, shrunk by a random amount to land inside often
    task automatic add_random_point();
        logic [31:0] x, y;
        int          k;
        k = $urandom_range(6);
        x = $urandom;
        y = $urandom;
        add_point(32'($signed(x) >>> k), 32'($signed(y) >>> (k + 1)));
    endtask

    initial begin
        walk_cfg = '{inv_a_squared: 32'd67108864, inv_b_squared: 32'd268435456,
                     step_size_h: 32'd429497, walk_increment: 31'd3796290,
                     path_count: 16'd10000, step_limit: 32'd16777216};
        walk_seed = SEED_RESET;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset configuration: outside points only, field extremes
        add_point(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        add_point(32'h8000_0000, 32'h8000_0000);
        add_point(32'h7FFF_FFFF, 32'h0000_0000);
        add_point(32'h0000_0000, 32'h8000_0000);
        add_point(32'hFFFF_FFFF, 32'h1000_0001);
        wait_drained();

        // Boundary and interior starts with few short paths
        write_all(32'd67108864, 32'd268435456, 32'd429497, 32'h0100_0000, 3, 12);
        add_point(32'h0000_0000, 32'h0000_0000);
        add_point(32'h2000_0000, 32'h0000_0000);
        add_point(32'hE000_0000, 32'h0000_0000);
        add_point(32'h0000_0000, 32'h1000_0000);
        add_point(32'h0000_0000, 32'hF000_0000);
        add_point(32'hFFFF_FFFF, 32'h0000_0001);
        wait_drained();

        // Zero step limit, zero path count, smallest time step and increment
        write_reg(REG_STEP_LIM, 0);
        write_reg(REG_STEP_H, 32'd1);
        add_point(32'h0800_0000, 32'h0400_0000);
        wait_drained();
        write_reg(REG_PATHS, 0);
        add_point(32'h0000_0000, 32'h0000_0000);
        wait_drained();
        write_all(32'd67108864, 32'd268435456, 32'hFFFF_FFFF, 32'd1, 2, 6);
        add_point(32'h1000_0000, 32'hF800_0000);
        wait_drained();

        // Walker saturation: tiny curvature, largest increment, capped paths
        write_all(32'd1, 32'd1, 32'd429497, 32'h7FFF_FFFF, 2, 5);
        add_point(32'h7FFF_FFFF, 32'h8000_0000);
        add_point(32'h0000_0000, 32'h0000_0000);
        wait_drained();

        // Largest step limit with an increment so large that any nonzero move leaves at once
        write_all(32'd67108864, 32'd268435456, 32'd429497, 32'h7FFF_FFFF, 3,
                  32'hFFFF_FFFF);
        add_point(32'h0000_0000, 32'h0000_0000);
        wait_drained();

        // Steepest ellipse, most paths: outside points only
        write_all(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd429497, 32'h0100_0000, 65535, 4);
        add_point(32'h1000_0000, 32'h0000_0000);
        add_point(32'h8000_0000, 32'h7FFF_FFFF);
        wait_drained();

        // Long receiver hold-off while the sender keeps offering
        write_all(32'd67108864, 32'd268435456, 32'd429497, 32'h0100_0000, 2, 12);
        recv_hold_go <= 1'b1;
        repeat (10) add_random_point();
        add_point(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        wait_drained();

        // Random phases under different idling mixes
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
                1: begin send_idle_pct = 49; recv_idle_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_idle_pct = 49; end
                default: begin send_idle_pct = 13; recv_idle_pct = 13; end
            endcase
            write_all($urandom_range(32'h0200_0000, 32'h2000_0000),
                      $urandom_range(32'h0200_0000, 32'h2000_0000),
                      $urandom, $urandom_range(32'h0040_0000, 32'h4000_0000),
                      $urandom_range(1, 3), $urandom_range(1, 12));
            for (int i = 0; i < 25; i++) begin
                add_random_point();
                // Pause the sender once until every answer is back
                if (phase == 1 && i == 12) begin
                    send_hold <= 1'b1;
                    @(negedge aclk);
                    while (s_tvalid || expected_results.size() > 0)
                        @(negedge aclk);
                    send_hold <= 1'b0;
                end
            end
            wait_drained();
        end

        repeat (200) @(posedge aclk);
        if (error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
